// ===== sv/circle_rect_overlap_test_defines.svh =====
// ----------------------------------------------------------------------------
// circle_rect_overlap_test_defines.svh
// Assertion macros used by the crot_chk port checks.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_RECT_OVERLAP_TEST_DEFINES_SVH
`define CIRCLE_RECT_OVERLAP_TEST_DEFINES_SVH

// Clocked assertion, quiet while reset is asserted.
`define CROT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CROT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== sv/crot_pkg.sv =====
// ----------------------------------------------------------------------------
// crot_pkg
// Types and constants shared by the circle/rectangle overlap test.
// ----------------------------------------------------------------------------
`default_nettype none

package crot_pkg;

    localparam int SIZE_BITS = 15;   // width, height, radius
    localparam int MAG_BITS  = 16;   // clamped gaps and radius limits
    localparam int SQ_BITS   = 2 * MAG_BITS;

    // kind codes: bit0 = first shape is a circle, bit1 = second shape is a circle
    localparam logic [1:0] KIND_RECT_RECT = 2'd0;
    localparam logic [1:0] KIND_CIRC_RECT = 2'd1;
    localparam logic [1:0] KIND_RECT_CIRC = 2'd2;
    localparam logic [1:0] KIND_CIRC_CIRC = 2'd3;

    // result of the gap stage: either settled, or a distance test still to do
    typedef struct packed {
        logic                decided;
        logic                hit;
        logic [MAG_BITS-1:0] u;
        logic [MAG_BITS-1:0] v;
        logic [MAG_BITS-1:0] lim;
    } t_gap;

    // result of the square stage
    typedef struct packed {
        logic               decided;
        logic               hit;
        logic [SQ_BITS-1:0] uu;
        logic [SQ_BITS-1:0] vv;
        logic [SQ_BITS-1:0] ll;
    } t_sq;

endpackage

`default_nettype wire

// ===== sv/crot_gap.sv =====
// ----------------------------------------------------------------------------
// crot_gap
// Gap stage: rectangle test, centre gaps, early reject/accept and clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module crot_gap #(
    parameter int COORD_BITS = 16
) (
    input  logic        [1:0]                     i_kind,
    input  logic signed [COORD_BITS-1:0]          i_first_x,
    input  logic signed [COORD_BITS-1:0]          i_first_y,
    input  logic        [crot_pkg::SIZE_BITS-1:0] i_first_width,
    input  logic        [crot_pkg::SIZE_BITS-1:0] i_first_height,
    input  logic signed [COORD_BITS-1:0]          i_second_x,
    input  logic signed [COORD_BITS-1:0]          i_second_y,
    input  logic        [crot_pkg::SIZE_BITS-1:0] i_second_width,
    input  logic        [crot_pkg::SIZE_BITS-1:0] i_second_height,
    output crot_pkg::t_gap                        o_gap
);

    localparam int MAX_BITS = (COORD_BITS > crot_pkg::SIZE_BITS) ?
                              COORD_BITS : crot_pkg::SIZE_BITS;
    localparam int DW = MAX_BITS + 4;

    logic signed [DW-1:0] ax, ay, aw, ah, bx, by, bw, bh;
    logic signed [DW-1:0] cx, cy, cr, rx, ry, rw, rh;
    logic signed [DW-1:0] gx_d, gy_d, gx, gy, r2;
    logic signed [DW-1:0] dx_d, dy_d, dx, dy, reach;
    logic                 rr_hit;

    assign ax = DW'(i_first_x);
    assign ay = DW'(i_first_y);
    assign aw = DW'({1'b0, i_first_width});
    assign ah = DW'({1'b0, i_first_height});
    assign bx = DW'(i_second_x);
    assign by = DW'(i_second_y);
    assign bw = DW'({1'b0, i_second_width});
    assign bh = DW'({1'b0, i_second_height});

    // both rectangles non-empty and half-open extents intersect
    assign rr_hit = (i_first_width != '0) && (i_first_height != '0) &&
                    (i_second_width != '0) && (i_second_height != '0) &&
                    (ax < bx + bw) && (bx < ax + aw) &&
                    (ay < by + bh) && (by < ay + ah);

    // swap so the circle is always c* and the rectangle r*
    assign cx = (i_kind == crot_pkg::KIND_RECT_CIRC) ? bx : ax;
    assign cy = (i_kind == crot_pkg::KIND_RECT_CIRC) ? by : ay;
    assign cr = (i_kind == crot_pkg::KIND_RECT_CIRC) ? bw : aw;
    assign rx = (i_kind == crot_pkg::KIND_RECT_CIRC) ? ax : bx;
    assign ry = (i_kind == crot_pkg::KIND_RECT_CIRC) ? ay : by;
    assign rw = (i_kind == crot_pkg::KIND_RECT_CIRC) ? aw : bw;
    assign rh = (i_kind == crot_pkg::KIND_RECT_CIRC) ? ah : bh;

    // doubled coordinates keep the rectangle centre exact
    assign gx_d = (cx <<< 1) - ((rx <<< 1) + rw);
    assign gy_d = (cy <<< 1) - ((ry <<< 1) + rh);
    assign gx   = gx_d[DW-1] ? -gx_d : gx_d;
    assign gy   = gy_d[DW-1] ? -gy_d : gy_d;
    assign r2   = cr <<< 1;

    assign dx_d  = ax - bx;
    assign dy_d  = ay - by;
    assign dx    = dx_d[DW-1] ? -dx_d : dx_d;
    assign dy    = dy_d[DW-1] ? -dy_d : dy_d;
    assign reach = aw + bw;

    always_comb begin
        o_gap.decided = 1'b1;
        o_gap.hit     = 1'b0;
        o_gap.u       = '0;
        o_gap.v       = '0;
        o_gap.lim     = '0;
        case (i_kind)
            crot_pkg::KIND_RECT_RECT: begin
                o_gap.hit = rr_hit;
            end
            crot_pkg::KIND_CIRC_CIRC: begin
                // drop far pairs before squaring; the rest fit in 16 bits
                if (!(dx > reach || dy > reach)) begin
                    o_gap.decided = 1'b0;
                    o_gap.u       = crot_pkg::MAG_BITS'(dx);
                    o_gap.v       = crot_pkg::MAG_BITS'(dy);
                    o_gap.lim     = crot_pkg::MAG_BITS'(reach);
                end
            end
            default: begin
                if (gx > rw + r2 || gy > rh + r2) begin
                    o_gap.hit = 1'b0;
                end else if (gx <= rw || gy <= rh) begin
                    o_gap.hit = 1'b1;
                end else begin
                    // corner region: distance to the nearest corner
                    o_gap.decided = 1'b0;
                    o_gap.u       = crot_pkg::MAG_BITS'(gx - rw);
                    o_gap.v       = crot_pkg::MAG_BITS'(gy - rh);
                    o_gap.lim     = crot_pkg::MAG_BITS'(r2);
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/crot_sq.sv =====
// ----------------------------------------------------------------------------
// crot_sq
// Square stage: squares of both gaps and of the radius limit.
// ----------------------------------------------------------------------------
`default_nettype none

module crot_sq (
    input  crot_pkg::t_gap i_gap,
    output crot_pkg::t_sq  o_sq
);

    assign o_sq.decided = i_gap.decided;
    assign o_sq.hit     = i_gap.hit;
    assign o_sq.uu      = crot_pkg::SQ_BITS'(i_gap.u) * crot_pkg::SQ_BITS'(i_gap.u);
    assign o_sq.vv      = crot_pkg::SQ_BITS'(i_gap.v) * crot_pkg::SQ_BITS'(i_gap.v);
    assign o_sq.ll      = crot_pkg::SQ_BITS'(i_gap.lim) * crot_pkg::SQ_BITS'(i_gap.lim);

endmodule

`default_nettype wire

// ===== sv/circle_rect_overlap_test.sv =====
// ----------------------------------------------------------------------------
// circle_rect_overlap_test
// Overlap test for one pair of shapes (rectangle or circle) per item.
//
//   channel  handshake                   payload
//   input    i_in_valid / o_in_ready     i_kind, i_first_*, i_second_*
//   output   o_out_valid / i_out_ready   o_overlap
//
// One item per cycle sustained while the output is not stalled; from accept to o_out_valid:
// input register, gap stage, square stage (16x16 multipliers), output register.
// Each stage moves on when the one after it is empty or moving, so bubbles close.
// A stalled output holds its item while up to three more items fill the stages.
// Reset clears all stage valid bits; o_in_ready is high right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_rect_overlap_test #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic        [1:0]                     i_kind,
    input  logic signed [COORD_BITS-1:0]          i_first_x,
    input  logic signed [COORD_BITS-1:0]          i_first_y,
    input  logic        [crot_pkg::SIZE_BITS-1:0] i_first_width,
    input  logic        [crot_pkg::SIZE_BITS-1:0] i_first_height,
    input  logic signed [COORD_BITS-1:0]          i_second_x,
    input  logic signed [COORD_BITS-1:0]          i_second_y,
    input  logic        [crot_pkg::SIZE_BITS-1:0] i_second_width,
    input  logic        [crot_pkg::SIZE_BITS-1:0] i_second_height,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_overlap
);

    logic                                  r_in_valid;
    logic        [1:0]                     r_kind;
    logic signed [COORD_BITS-1:0]          r_first_x, r_first_y, r_second_x, r_second_y;
    logic        [crot_pkg::SIZE_BITS-1:0] r_first_width, r_first_height;
    logic        [crot_pkg::SIZE_BITS-1:0] r_second_width, r_second_height;

    logic           r_gap_valid;
    crot_pkg::t_gap r_gap;
    crot_pkg::t_gap n_gap;

    logic           r_sq_valid;
    crot_pkg::t_sq  r_sq;
    crot_pkg::t_sq  n_sq;

    logic           r_out_valid;
    logic           r_overlap;
    logic           n_overlap;

    logic           go_in, go_gap, go_sq, go_out;
    logic [crot_pkg::SQ_BITS:0] dist_sum;

    assign go_out = !r_out_valid || i_out_ready;
    assign go_sq  = !r_sq_valid  || go_out;
    assign go_gap = !r_gap_valid || go_sq;
    assign go_in  = !r_in_valid  || go_gap;

    assign o_in_ready  = go_in;
    assign o_out_valid = r_out_valid;
    assign o_overlap   = r_overlap;

    crot_gap #(
        .COORD_BITS(COORD_BITS)
    ) u_gap (
        .i_kind         (r_kind),
        .i_first_x      (r_first_x),
        .i_first_y      (r_first_y),
        .i_first_width  (r_first_width),
        .i_first_height (r_first_height),
        .i_second_x     (r_second_x),
        .i_second_y     (r_second_y),
        .i_second_width (r_second_width),
        .i_second_height(r_second_height),
        .o_gap          (n_gap)
    );

    crot_sq u_sq (
        .i_gap(r_gap),
        .o_sq (n_sq)
    );

    assign dist_sum  = {1'b0, r_sq.uu} + {1'b0, r_sq.vv};
    assign n_overlap = r_sq.decided ? r_sq.hit : (dist_sum <= {1'b0, r_sq.ll});

    // control: stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_gap_valid <= 1'b0;
            r_sq_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (go_in)  r_in_valid  <= i_in_valid;
            if (go_gap) r_gap_valid <= r_in_valid;
            if (go_sq)  r_sq_valid  <= r_gap_valid;
            if (go_out) r_out_valid <= r_sq_valid;
        end
    end

    // payload: advance with the stage, hold otherwise
    always_ff @(posedge i_clk) begin
        if (go_in && i_in_valid) begin
            r_kind          <= i_kind;
            r_first_x       <= i_first_x;
            r_first_y       <= i_first_y;
            r_first_width   <= i_first_width;
            r_first_height  <= i_first_height;
            r_second_x      <= i_second_x;
            r_second_y      <= i_second_y;
            r_second_width  <= i_second_width;
            r_second_height <= i_second_height;
        end
        if (go_gap) r_gap     <= n_gap;
        if (go_sq)  r_sq      <= n_sq;
        if (go_out) r_overlap <= n_overlap;
    end

endmodule

`default_nettype wire

// ===== sv/crot_chk.sv =====
// ----------------------------------------------------------------------------
// crot_chk
// Port-level checks for circle_rect_overlap_test, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circle_rect_overlap_test_defines.svh"

module crot_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic [1:0]                     i_kind,
    input logic [crot_pkg::SIZE_BITS-1:0] i_first_width,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic                           o_overlap
);

    logic in_acc;
    logic empty_rr;

    assign in_acc   = i_in_valid && o_in_ready;
    assign empty_rr = in_acc && (i_kind == crot_pkg::KIND_RECT_RECT) &&
                      (i_first_width == '0);

    // held result stays put
    `CROT_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_overlap), "stalled result changed")

    // input back-pressure only comes from a stalled output
    `CROT_ASSERT(a_in_stall, !o_in_ready |-> o_out_valid && !i_out_ready, "input stalled without output stall")

    // with the output open, an accepted item is followed by a valid result
    `CROT_ASSERT(a_latency, in_acc ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> o_out_valid, "result missing after latency")

    // an empty rectangle never overlaps another rectangle
    `CROT_ASSERT(a_empty_rect, empty_rr ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> !o_overlap, "empty rectangle reported overlap")

    // reset empties the pipeline and opens the input
    `CROT_ASSERT_ALWAYS(a_reset, !i_rst_n |=> !o_out_valid && o_in_ready, "pipeline not empty after reset")

endmodule

bind circle_rect_overlap_test crot_chk u_crot_chk (.*);

`default_nettype wire

// ===== verif/circle_rect_overlap_test_checker.sv =====
// ----------------------------------------------------------------------------
// circle_rect_overlap_test_checker
// Watches both channels of the shape overlap test, predicts the overlap bit
// for every accepted item and compares it with the results in order.
// ----------------------------------------------------------------------------
module circle_rect_overlap_test_checker #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic        [1:0]                     i_kind,
    input  logic signed [COORD_BITS-1:0]          i_first_x,
    input  logic signed [COORD_BITS-1:0]          i_first_y,
    input  logic        [crot_pkg::SIZE_BITS-1:0] i_first_width,
    input  logic        [crot_pkg::SIZE_BITS-1:0] i_first_height,
    input  logic signed [COORD_BITS-1:0]          i_second_x,
    input  logic signed [COORD_BITS-1:0]          i_second_y,
    input  logic        [crot_pkg::SIZE_BITS-1:0] i_second_width,
    input  logic        [crot_pkg::SIZE_BITS-1:0] i_second_height,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic                                  i_overlap,
    output int                                    o_errors,
    output int                                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic overlap_due[$];
    int   results_seen = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // Work on doubled coordinates so the rectangle centre x + w/2 stays exact.
    function automatic logic circle_box_hits(longint cx, longint cy, longint r,
                                             longint rx, longint ry,
                                             longint rw, longint rh);
        longint r2, gx, gy, ex, ey;
        r2 = 2 * r;
        gx = 2 * cx - (2 * rx + rw);
        gy = 2 * cy - (2 * ry + rh);
        if (gx < 0) gx = -gx;
        if (gy < 0) gy = -gy;
        if (gx > rw + r2 || gy > rh + r2) return 1'b0;
        if (gx <= rw || gy <= rh) return 1'b1;
        ex = gx - rw;
        ey = gy - rh;
        return (ex * ex + ey * ey <= r2 * r2);
    endfunction

    function automatic logic predict_overlap(logic [1:0] kind,
                                             longint ax, longint ay,
                                             longint aw, longint ah,
                                             longint bx, longint by,
                                             longint bw, longint bh);
        longint reach, dx, dy, lo, hi;
        logic   hit;
        case (kind)
            crot_pkg::KIND_CIRC_CIRC: begin
                reach = aw + bw;
                dx = ax - bx;
                dy = ay - by;
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                if (dx > reach || dy > reach) hit = 1'b0;
                else hit = (dx * dx + dy * dy <= reach * reach);
            end
            crot_pkg::KIND_RECT_RECT: begin
                hit = 1'b0;
                if (aw > 0 && ah > 0 && bw > 0 && bh > 0) begin
                    lo = (ax > bx) ? ax : bx;
                    hi = (ax + aw < bx + bw) ? ax + aw : bx + bw;
                    if (hi > lo) begin
                        lo = (ay > by) ? ay : by;
                        hi = (ay + ah < by + bh) ? ay + ah : by + bh;
                        hit = (hi > lo);
                    end
                end
            end
            crot_pkg::KIND_CIRC_RECT: hit = circle_box_hits(ax, ay, aw, bx, by, bw, bh);
            default:                  hit = circle_box_hits(bx, by, bw, ax, ay, aw, ah);
        endcase
        return hit;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: result %0d: %s", $time, results_seen, what);
        o_errors = o_errors + 1;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // Retire the result first: it can never belong to an item taken this edge.
            if (i_out_valid && i_out_ready) begin
                if (overlap_due.size() == 0) begin
                    report_mismatch("result with no item pending");
                end else if (i_overlap !== overlap_due[0]) begin
                    report_mismatch($sformatf("overlap got %b expected %b",
                                              i_overlap, overlap_due[0]));
                    void'(overlap_due.pop_front());
                end else begin
                    void'(overlap_due.pop_front());
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready) begin
                overlap_due.push_back(predict_overlap(i_kind,
                    longint'(i_first_x), longint'(i_first_y),
                    longint'(i_first_width), longint'(i_first_height),
                    longint'(i_second_x), longint'(i_second_y),
                    longint'(i_second_width), longint'(i_second_height)));
            end
            o_pending = overlap_due.size();
        end
    end

endmodule

// ===== verif/circle_rect_overlap_test_tb.sv =====
// ----------------------------------------------------------------------------
// circle_rect_overlap_test_tb
// Drives shape pairs into the overlap test: a directed set of edge, corner,
// touching and extreme cases, then random pairs near and far apart, under
// changing sender and receiver stalls. The checker predicts and compares.
// ----------------------------------------------------------------------------
module circle_rect_overlap_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS  = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                                  in_valid      = 1'b0;
    logic                                  in_ready;
    logic        [1:0]                     kind          = crot_pkg::KIND_RECT_RECT;
    logic signed [COORD_BITS-1:0]          first_x       = '0;
    logic signed [COORD_BITS-1:0]          first_y       = '0;
    logic        [crot_pkg::SIZE_BITS-1:0] first_width   = '0;
    logic        [crot_pkg::SIZE_BITS-1:0] first_height  = '0;
    logic signed [COORD_BITS-1:0]          second_x      = '0;
    logic signed [COORD_BITS-1:0]          second_y      = '0;
    logic        [crot_pkg::SIZE_BITS-1:0] second_width  = '0;
    logic        [crot_pkg::SIZE_BITS-1:0] second_height = '0;
    logic                                  out_valid;
    logic                                  out_ready     = 1'b0;
    logic                                  overlap;

    int errors;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    circle_rect_overlap_test #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_kind         (kind),
        .i_first_x      (first_x),
        .i_first_y      (first_y),
        .i_first_width  (first_width),
        .i_first_height (first_height),
        .i_second_x     (second_x),
        .i_second_y     (second_y),
        .i_second_width (second_width),
        .i_second_height(second_height),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_overlap      (overlap)
    );

    circle_rect_overlap_test_checker #(
        .COORD_BITS(COORD_BITS)
    ) u_overlap_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_kind         (kind),
        .i_first_x      (first_x),
        .i_first_y      (first_y),
        .i_first_width  (first_width),
        .i_first_height (first_height),
        .i_second_x     (second_x),
        .i_second_y     (second_y),
        .i_second_width (second_width),
        .i_second_height(second_height),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_overlap      (overlap),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready = 1'b0;
        end else begin
            out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("circle_rect_overlap_test_tb: errors");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_pair(input logic [1:0] k,
                             input int ax, input int ay, input int aw, input int ah,
                             input int bx, input int by, input int bw, input int bh);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        kind          = k;
        first_x       = ax[COORD_BITS-1:0];
        first_y       = ay[COORD_BITS-1:0];
        first_width   = aw[crot_pkg::SIZE_BITS-1:0];
        first_height  = ah[crot_pkg::SIZE_BITS-1:0];
        second_x      = bx[COORD_BITS-1:0];
        second_y      = by[COORD_BITS-1:0];
        second_width  = bw[crot_pkg::SIZE_BITS-1:0];
        second_height = bh[crot_pkg::SIZE_BITS-1:0];
        in_valid      = 1'b1;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Mostly pairs close together so both answers turn up; some span the full range.
    task automatic send_random_pair();
        int sel, spread, size_max, ax, ay;
        logic [1:0] k;
        sel = $urandom_range(0, 9);
        k   = 2'($urandom_range(0, 3));
        ax  = $urandom;
        ay  = $urandom;
        if (sel >= 8) begin
            send_pair(k, ax, ay, $urandom_range(0, 32767), $urandom_range(0, 32767),
                      $urandom, $urandom, $urandom_range(0, 32767),
                      $urandom_range(0, 32767));
        end else begin
            spread   = (sel < 6) ? 48 : 4096;
            size_max = (sel < 6) ? 40 : 4096;
            send_pair(k, ax, ay,
                      ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, size_max),
                      ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, size_max),
                      ax + $urandom_range(0, 2 * spread) - spread,
                      ay + $urandom_range(0, 2 * spread) - spread,
                      ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, size_max),
                      ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, size_max));
        end
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) hold_until_drained();
            send_random_pair();
        end
        hold_until_drained();
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        send_idle_pct = 24;
        recv_idle_pct = 81;

        // rectangles: full extent, half-open edges, one pixel overlap, empty sides
        send_pair(crot_pkg::KIND_RECT_RECT, -32768, -32768, 32767, 32767,
                  -32768, -32768, 32767, 32767);
        send_pair(crot_pkg::KIND_RECT_RECT, 32767, 32767, 32767, 32767,
                  -32768, -32768, 32767, 32767);
        send_pair(crot_pkg::KIND_RECT_RECT, 0, 0, 10, 10, 10, 0, 10, 10);
        send_pair(crot_pkg::KIND_RECT_RECT, 0, 0, 10, 10, 9, 9, 10, 10);
        send_pair(crot_pkg::KIND_RECT_RECT, 0, 0, 0, 10, 0, 0, 10, 10);
        send_pair(crot_pkg::KIND_RECT_RECT, 0, 0, 10, 10, 2, 2, 5, 0);
        // circles: exact touch, just apart, far corners, maximum radii
        send_pair(crot_pkg::KIND_CIRC_CIRC, 0, 0, 3, 32767, 3, 4, 2, 0);
        send_pair(crot_pkg::KIND_CIRC_CIRC, 0, 0, 3, 0, 3, 5, 2, 32767);
        send_pair(crot_pkg::KIND_CIRC_CIRC, -32768, -32768, 0, 0, 32767, 32767, 0, 0);
        send_pair(crot_pkg::KIND_CIRC_CIRC, -32768, 0, 32767, 0, 32767, 0, 32767, 0);
        send_pair(crot_pkg::KIND_CIRC_CIRC, -32768, 0, 32767, 0, 32766, 0, 32767, 0);
        send_pair(crot_pkg::KIND_CIRC_CIRC, 5, 5, 0, 0, 5, 5, 0, 0);
        send_pair(crot_pkg::KIND_CIRC_CIRC, 3, 4, 0, 0, 0, 0, 5, 0);
        // circle against rectangle in both orders: corner touch and miss, inside, edge
        send_pair(crot_pkg::KIND_CIRC_RECT, 13, 14, 5, 0, 0, 0, 10, 10);
        send_pair(crot_pkg::KIND_CIRC_RECT, 13, 14, 4, 0, 0, 0, 10, 10);
        send_pair(crot_pkg::KIND_RECT_CIRC, 0, 0, 10, 10, 13, 14, 5, 32767);
        send_pair(crot_pkg::KIND_RECT_CIRC, 0, 0, 10, 10, 13, 14, 4, 0);
        send_pair(crot_pkg::KIND_CIRC_RECT, 5, 5, 0, 0, 0, 0, 10, 10);
        send_pair(crot_pkg::KIND_CIRC_RECT, 10, 3, 0, 0, 0, 0, 10, 10);
        send_pair(crot_pkg::KIND_RECT_CIRC, 0, 0, 10, 10, 15, 5, 5, 0);
        send_pair(crot_pkg::KIND_RECT_CIRC, 0, 0, 10, 10, 16, 5, 5, 0);
        // empty rectangles against circles: a segment and a point; then extreme corners
        send_pair(crot_pkg::KIND_CIRC_RECT, 0, 3, 3, 0, -5, 0, 10, 0);
        send_pair(crot_pkg::KIND_RECT_CIRC, 4, 4, 0, 0, 7, 8, 5, 0);
        send_pair(crot_pkg::KIND_CIRC_RECT, -32768, -32768, 32767, 32767,
                  32767, 32767, 32767, 32767);
        send_pair(crot_pkg::KIND_RECT_CIRC, 32767, -32768, 32767, 32767,
                  -32768, 32767, 32767, 0);
        hold_until_drained();

        run_random(300);
        send_idle_pct = 81;
        recv_idle_pct = 24;
        run_random(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(200);

        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("circle_rect_overlap_test_tb: clean");
        end else begin
            $display("circle_rect_overlap_test_tb: errors");
        end
        $finish;
    end

endmodule
